// File: sv/kfts_pkg.sv
// Package with types and constants for the keyframe track sampler.
`default_nettype none
package kfts_pkg;

  localparam int MaxKeys  = 64;
  localparam int SlotW    = $clog2(MaxKeys);
  localparam int CountW   = 7;
  localparam int TimeW    = 32;
  localparam int ValW     = 32;

  localparam logic [0:0] ModeLoad   = 1'b0;
  localparam logic [0:0] ModeSample = 1'b1;

  localparam logic [0:0] RegKeyCount = 1'b0;
  localparam logic [0:0] RegDuration = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [5:0]              key_slot;
    logic [31:0]             key_time;
    logic signed [31:0]      key_x;
    logic signed [31:0]      key_y;
    logic signed [31:0]      key_z;
    logic [31:0]             sample_time;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]      out_x;
    logic signed [31:0]      out_y;
    logic signed [31:0]      out_z;
    logic [5:0]              segment;
  } out_word_t;

  typedef enum logic [3:0] {
    StIdle,
    StMod,
    StRead0,
    StCheck0,
    StScanRd,
    StScan,
    StDiv,
    StMul,
    StEmit
  } state_e;

endpackage
`default_nettype wire

// File: sv/keyframe_track_sampler.sv
// Top level of the keyframe track sampler: key memories, search sequencer and arithmetic.
//
//  Channel | Direction | Handshake                  | Word
//  cmd     | in        | start / busy               | in_word_i (kfts_pkg::in_word_t)
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//  result  | out       | done_o strobe              | out_word_o (kfts_pkg::out_word_t)
//
// A load word keeps the block busy in StEmit, where the key is written. A sample word
// runs the serial modulo in StMod (t is the sample time itself when the duration is
// zero), reads key 0 in StRead0, checks it in StCheck0 and visits each further key (up
// to 63) in StScanRd and StScan; to interpolate it runs the serial fraction division in
// StDiv and the multipliers in StMul, then emits in StEmit. The registered memory read
// is why each scanned key needs both scan states. Reset clears control state and sets
// key_count to 1 and track_duration to 65536; the memories hold garbage until written.
// The receiver cannot stall: done_o is high for one cycle with the result.
`default_nettype none
module keyframe_track_sampler (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  input  wire kfts_pkg::in_word_t  in_word_i,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire  [0:0]               cfg_index_i,
  input  wire  [31:0]              cfg_data_i,
  output logic                     done_o,
  output kfts_pkg::out_word_t      out_word_o
);

  // Key memories.
  logic [31:0] time_mem [kfts_pkg::MaxKeys];
  logic [95:0] val_mem  [kfts_pkg::MaxKeys];
  logic [31:0] time_rd_q;
  logic [95:0] val_rd_q;
  logic        we;
  logic [kfts_pkg::SlotW-1:0] waddr, raddr;
  logic [31:0] wtime;
  logic [95:0] wval;

  kfts_pkg::state_e state_q, state_d;
  kfts_pkg::in_word_t in_q;
  logic [6:0]  count_q;
  logic [31:0] dur_q;
  logic [6:0]  n_eff;
  logic [kfts_pkg::SlotW-1:0] idx_q, idx_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;     // partial remainder
  logic [31:0] quo_q, quo_d;     // dividend bits / quotient
  logic [31:0] t_q, t_d;
  logic [31:0] t0_q, t0_d;
  logic [95:0] v0_q, v0_d;
  logic [95:0] v1_q, v1_d;
  logic [31:0] den_q, den_d;
  logic [16:0] f_q, f_d;
  logic signed [49:0] prod_q [3];
  logic signed [49:0] prod_d [3];
  logic [5:0]  seg_q, seg_d;
  logic        interp_q, interp_d;
  logic [32:0] sub;
  logic [31:0] dt;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 7'd1;
      dur_q   <= 32'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kfts_pkg::RegKeyCount: count_q <= cfg_data_i[6:0];
        kfts_pkg::RegDuration: dur_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (count_q == 7'd0) n_eff = 7'd1;
    else if (count_q > 7'(kfts_pkg::MaxKeys)) n_eff = 7'(kfts_pkg::MaxKeys);
    else n_eff = count_q;
  end

  // Memory ports: write for loads, registered read for the scan.
  always_ff @(posedge clk_i) begin
    if (we) begin
      time_mem[waddr] <= wtime;
      val_mem[waddr]  <= wval;
    end
    time_rd_q <= time_mem[raddr];
    val_rd_q  <= val_mem[raddr];
  end

  assign waddr = in_q.key_slot;
  assign wtime = in_q.key_time;
  assign wval  = {in_q.key_x, in_q.key_y, in_q.key_z};

  // State register and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= kfts_pkg::StIdle;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) in_q <= in_word_i;
    idx_q <= idx_d; cnt_q <= cnt_d; rem_q <= rem_d; quo_q <= quo_d;
    t_q <= t_d; t0_q <= t0_d; v0_q <= v0_d; v1_q <= v1_d; den_q <= den_d;
    f_q <= f_d; seg_q <= seg_d; interp_q <= interp_d;
    for (int c = 0; c < 3; c++) prod_q[c] <= prod_d[c];
  end

  // Shared restoring divider step: compare and subtract.
  assign sub = {rem_q, quo_q[31]} - {1'b0, (state_q == kfts_pkg::StMod) ? dur_q : den_q};

  // Distance from the lower key time to the query time.
  assign dt = t_q - t0_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kfts_pkg::StIdle: if (start)
        state_d = (in_word_i.mode == kfts_pkg::ModeLoad) ? kfts_pkg::StEmit : kfts_pkg::StMod;
      kfts_pkg::StMod:    if (cnt_q == 6'd31 || dur_q == 32'd0) state_d = kfts_pkg::StRead0;
      kfts_pkg::StRead0:  state_d = kfts_pkg::StCheck0;
      kfts_pkg::StCheck0:
        if (n_eff == 7'd1 || t_q <= time_rd_q) state_d = kfts_pkg::StEmit;
        else state_d = kfts_pkg::StScanRd;
      kfts_pkg::StScanRd: state_d = kfts_pkg::StScan;
      kfts_pkg::StScan:
        if (t_q <= time_rd_q) state_d = (time_rd_q == t0_q) ? kfts_pkg::StMul : kfts_pkg::StDiv;
        else if ({1'b0, idx_q} + 7'd1 >= n_eff) state_d = kfts_pkg::StEmit;
        else state_d = kfts_pkg::StScanRd;
      kfts_pkg::StDiv:    if (cnt_q == 6'd32) state_d = kfts_pkg::StMul;
      kfts_pkg::StMul:    state_d = interp_q ? kfts_pkg::StEmit : kfts_pkg::StMul;
      kfts_pkg::StEmit:   state_d = kfts_pkg::StIdle;
      default:            state_d = kfts_pkg::StIdle;
    endcase
  end

  // Datapath control per state.
  always_comb begin
    idx_d = idx_q; cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q; t_d = t_q;
    t0_d = t0_q; v0_d = v0_q; v1_d = v1_q; den_d = den_q; f_d = f_q;
    seg_d = seg_q; interp_d = interp_q;
    for (int c = 0; c < 3; c++) prod_d[c] = prod_q[c];
    raddr = idx_q;
    we = 1'b0;
    unique case (state_q)
      kfts_pkg::StIdle: begin
        cnt_d = '0; rem_d = '0; quo_d = in_word_i.sample_time;
        idx_d = '0; interp_d = 1'b0;
      end
      kfts_pkg::StMod: begin
        if (dur_q == 32'd0) begin
          t_d = quo_q;
        end else begin
          rem_d = sub[32] ? {rem_q[30:0], quo_q[31]} : sub[31:0];
          quo_d = {quo_q[30:0], 1'b0};
          cnt_d = cnt_q + 6'd1;
          t_d = sub[32] ? {rem_q[30:0], quo_q[31]} : sub[31:0];
        end
        raddr = '0;
      end
      kfts_pkg::StRead0: raddr = '0;
      kfts_pkg::StCheck0: begin
        t0_d = time_rd_q; v0_d = val_rd_q; seg_d = '0; v1_d = val_rd_q;
        idx_d = kfts_pkg::SlotW'(1); raddr = kfts_pkg::SlotW'(1);
      end
      kfts_pkg::StScanRd: raddr = idx_q;
      kfts_pkg::StScan: begin
        if (t_q <= time_rd_q) begin
          v1_d = val_rd_q;
          seg_d = 6'(idx_q - 1'b1);
          den_d = time_rd_q - t0_q;
          f_d = '0;
          cnt_d = '0;
          // Dividend (t-t0)<<16: the upper 16 bits go to the remainder, the rest to quo.
          rem_d = {16'h0, dt[31:16]};
          quo_d = {dt[15:0], 16'h0};
        end else begin
          t0_d = time_rd_q; v0_d = val_rd_q; v1_d = val_rd_q;
          seg_d = 6'(idx_q);
          idx_d = idx_q + kfts_pkg::SlotW'(1);
          raddr = idx_q + kfts_pkg::SlotW'(1);
        end
      end
      kfts_pkg::StDiv: begin
        // 48-bit dividend (t-t0)<<16: high 16 bits preloaded in rem, low 32 in quo.
        if (cnt_q != 6'd32) begin
          rem_d = sub[32] ? {rem_q[30:0], quo_q[31]} : sub[31:0];
          quo_d = {quo_q[30:0], ~sub[32]};
          cnt_d = cnt_q + 6'd1;
        end else begin
          f_d = quo_q[16:0];
        end
      end
      kfts_pkg::StMul: begin
        for (int c = 0; c < 3; c++)
          prod_d[c] = 50'($signed(33'($signed(v1_q[95-32*c -: 32]))
                      - 33'($signed(v0_q[95-32*c -: 32])))) * $signed({1'b0, f_q});
        interp_d = 1'b1;
      end
      kfts_pkg::StEmit: begin
        if (in_q.mode == kfts_pkg::ModeLoad) we = 1'b1;
      end
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    busy = (state_q != kfts_pkg::StIdle);
    done_o = (state_q == kfts_pkg::StEmit) && (in_q.mode == kfts_pkg::ModeSample);
    for (int c = 0; c < 3; c++) begin
      if (interp_q)
        out_word_o[101-32*c -: 32] = v0_q[95-32*c -: 32] + prod_q[c][47:16];
      else
        out_word_o[101-32*c -: 32] = v1_q[95-32*c -: 32];
    end
    out_word_o.segment = seg_q;
  end

endmodule
`default_nettype wire

// File: sv/kfts_checker.sv
// Port-level checker for the keyframe track sampler, bound to the top level.
`default_nettype none
module kfts_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire start,
  input wire busy,
  input wire done_i,
  input wire cfg_ready_i
);
  // A result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i) else $error("done held over two cycles");
  // Results only appear while a word is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> busy) else $error("done without busy");
  // An accepted word makes the block busy.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept without busy");
  // The block frees up after a result.
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !busy) else $error("busy after done");
  // Configuration writes are always taken.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i) else $error("configuration port not ready");
endmodule

bind keyframe_track_sampler kfts_checker u_kfts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_i(done_o), .cfg_ready_i(cfg_ready_o)
);
`default_nettype wire
